// ===== sv/msp_pkg.sv =====
// shared types and constants for the matrix saddle point finder
// no dependencies; imported by msp_ctrl, msp_dp and the core module
package msp_pkg;

    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 5;
    localparam int OUT_IDX_W     = 4;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_COLS  = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

    // register index, taken from paddr bit 2
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic load_accept;
        logic load_update;
        logic scan_start;
        logic out_load;
    } msp_cmd_t;

    typedef struct packed {
        logic last_elem;
        logic out_free;
        logic scan_done;
    } msp_status_t;

endpackage

// ===== sv/msp_ram.sv =====
// generic single write port RAM with registered read
// no dependencies
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/msp_ctrl.sv =====
// sequencer for load, scan and result hand-off
// depends on msp_pkg for the command and status structs
module msp_ctrl
    import msp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msp_status_t status,
    output msp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_UPDATE,
        S_SCAN_WAIT,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load_accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.load_update = 1'b1;
                state_next      = status.last_elem ? S_SCAN_WAIT : S_LOAD;
            end
            S_SCAN_WAIT:
            begin
                // scan only once the output register will be empty at the end
                if (status.out_free)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_LOAD);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// ===== sv/msp_dp.sv =====
// datapath: element store, row maxima, column minima, scan pipeline, result register
// depends on msp_pkg and msp_ram
module msp_dp
    import msp_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  msp_cmd_t                 cmd,
    output msp_status_t              status,
    input  logic                     restart,
    input  logic [SIZE_W-1:0]        num_rows,
    input  logic [SIZE_W-1:0]        num_cols,
    input  logic signed [DATA_W-1:0] elem_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [OUT_IDX_W-1:0]     saddle_row,
    output logic [OUT_IDX_W-1:0]     saddle_col,
    output logic signed [DATA_W-1:0] saddle_value
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 32);

    logic [SW-1:0] rows_eff;
    logic [SW-1:0] cols_eff;

    // load side
    logic [RW-1:0]            cur_row_reg;
    logic [CW-1:0]            cur_col_reg;
    logic signed [DATA_W-1:0] v_reg;
    logic signed [DATA_W-1:0] run_max_reg;
    logic signed [DATA_W-1:0] new_rmax;
    logic signed [DATA_W-1:0] new_cmin;
    logic                     row_last;
    logic                     col_last;

    // scan side
    logic          scan_run_reg;
    logic [RW-1:0] si_reg;
    logic [CW-1:0] sj_reg;
    logic          chk_valid_reg;
    logic          chk_last_reg;
    logic [RW-1:0] chk_i_reg;
    logic [CW-1:0] chk_j_reg;
    logic          si_last;
    logic          sj_last;
    logic          hit;

    // RAM ports
    logic [AW-1:0]     mat_waddr;
    logic [AW-1:0]     mat_raddr;
    logic [DATA_W-1:0] mat_rdata;
    logic [DATA_W-1:0] rmax_rdata;
    logic [DATA_W-1:0] cmin_rdata;
    logic [CW-1:0]     cmin_raddr;

    // result register
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [OUT_IDX_W-1:0]     row_out_reg;
    logic [OUT_IDX_W-1:0]     col_out_reg;
    logic signed [DATA_W-1:0] value_out_reg;
    logic [RW+OUT_IDX_W-1:0]  chk_i_ext;
    logic [CW+OUT_IDX_W-1:0]  chk_j_ext;

    always_comb
    begin
        if (num_rows == '0)
            rows_eff = SW'(1);
        else if (SW'(num_rows) > SW'(MAX_ROWS))
            rows_eff = SW'(MAX_ROWS);
        else
            rows_eff = SW'(num_rows);

        if (num_cols == '0)
            cols_eff = SW'(1);
        else if (SW'(num_cols) > SW'(MAX_COLS))
            cols_eff = SW'(MAX_COLS);
        else
            cols_eff = SW'(num_cols);
    end

    assign row_last = (SW'(cur_row_reg) == rows_eff - SW'(1));
    assign col_last = (SW'(cur_col_reg) == cols_eff - SW'(1));
    assign si_last  = (SW'(si_reg) == rows_eff - SW'(1));
    assign sj_last  = (SW'(sj_reg) == cols_eff - SW'(1));

    // running extremes seeded from the first element of the row or column
    always_comb
    begin
        if (cur_col_reg == '0 || v_reg > run_max_reg)
            new_rmax = v_reg;
        else
            new_rmax = run_max_reg;

        if (cur_row_reg == '0 || v_reg < $signed(cmin_rdata))
            new_cmin = v_reg;
        else
            new_cmin = $signed(cmin_rdata);
    end

    assign mat_waddr  = AW'(AW'(cur_row_reg) * AW'(MAX_COLS)) + AW'(cur_col_reg);
    assign mat_raddr  = AW'(AW'(si_reg) * AW'(MAX_COLS)) + AW'(sj_reg);
    assign cmin_raddr = scan_run_reg ? sj_reg : cur_col_reg;

    msp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (cmd.load_update),
        .waddr (mat_waddr),
        .wdata (v_reg),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    msp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS)
    ) u_rmax_ram (
        .clk   (clk),
        .we    (cmd.load_update && col_last),
        .waddr (cur_row_reg),
        .wdata (new_rmax),
        .raddr (si_reg),
        .rdata (rmax_rdata)
    );

    msp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_COLS)
    ) u_cmin_ram (
        .clk   (clk),
        .we    (cmd.load_update),
        .waddr (cur_col_reg),
        .wdata (new_cmin),
        .raddr (cmin_raddr),
        .rdata (cmin_rdata)
    );

    assign hit = (mat_rdata == rmax_rdata) && (mat_rdata == cmin_rdata);

    always_comb
    begin
        chk_i_ext = {{OUT_IDX_W{1'b0}}, chk_i_reg};
        chk_j_ext = {{OUT_IDX_W{1'b0}}, chk_j_reg};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            scan_run_reg  <= 1'b0;
            si_reg        <= '0;
            sj_reg        <= '0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (cmd.load_update)
            begin
                if (col_last)
                begin
                    cur_col_reg <= '0;
                    cur_row_reg <= row_last ? '0 : cur_row_reg + RW'(1);
                end
                else
                begin
                    cur_col_reg <= cur_col_reg + CW'(1);
                end
            end

            if (cmd.scan_start)
            begin
                scan_run_reg  <= 1'b1;
                si_reg        <= '0;
                sj_reg        <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.out_load)
            begin
                scan_run_reg  <= 1'b0;
                chk_valid_reg <= 1'b0;
            end
            else if (scan_run_reg)
            begin
                // read issued this cycle, compared next cycle
                chk_valid_reg <= 1'b1;
                chk_last_reg  <= si_last && sj_last;
                if (sj_last)
                begin
                    sj_reg <= '0;
                    si_reg <= si_last ? '0 : si_reg + RW'(1);
                    if (si_last)
                    begin
                        scan_run_reg <= 1'b0;
                    end
                end
                else
                begin
                    sj_reg <= sj_reg + CW'(1);
                end
            end
            else
            begin
                chk_valid_reg <= 1'b0;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_accept)
        begin
            v_reg <= elem_value;
        end
        if (cmd.load_update)
        begin
            run_max_reg <= new_rmax;
        end
        if (scan_run_reg && !cmd.scan_start && !cmd.out_load)
        begin
            chk_i_reg <= si_reg;
            chk_j_reg <= sj_reg;
        end
        if (cmd.out_load)
        begin
            found_reg     <= hit;
            row_out_reg   <= hit ? chk_i_ext[OUT_IDX_W-1:0] : '0;
            col_out_reg   <= hit ? chk_j_ext[OUT_IDX_W-1:0] : '0;
            value_out_reg <= hit ? $signed(mat_rdata) : '0;
        end
    end

    assign status.last_elem = row_last && col_last;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.scan_done = chk_valid_reg && (hit || chk_last_reg);

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign saddle_row   = row_out_reg;
    assign saddle_col   = col_out_reg;
    assign saddle_value = value_out_reg;

    a_load_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(cur_row_reg) < rows_eff) && (SW'(cur_col_reg) < cols_eff))
        else $error("load counters outside matrix size");

    a_no_update_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_update |-> !scan_run_reg && !chk_valid_reg)
        else $error("element update while scan in flight");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_miss_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |->
            (row_out_reg == '0) && (col_out_reg == '0) && (value_out_reg == '0))
        else $error("no saddle point but nonzero fields");

endmodule

// ===== sv/matrix_saddle_point_finder_core.sv =====
// Matrix saddle point finder.
// Input channel (in_valid/in_ready, elem_value): matrix elements in row-major order,
// num_rows x num_cols of them per matrix. Each element is transferred first and
// then used to update the element store, row maximum and column minimum.
// After the last element the stored matrix is scanned in row-major order, one
// entry per cycle, through the three RAM read ports. The result (found, saddle_row,
// saddle_col, saddle_value) appears on the output channel (out_valid/out_ready)
// once the scan reaches the first saddle point in row-major order, or its last
// entry when there is none.
// Sizes come from the APB registers num_rows (0x0) and num_cols (0x4); a zero is
// taken as 1 and values above the maximum saturate. A register write restarts
// loading at element (0,0).
// Reset: sizes go to 3x3, load position to (0,0), no result pending. The stores
// need no clearing, so the block is ready right after reset.
// A stalled receiver holds the result in the output register; loading of the next
// matrix continues meanwhile, and its scan starts once the result has been taken.
// depends on msp_pkg, msp_ctrl, msp_dp, msp_ram
module matrix_saddle_point_finder_core
    import msp_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] elem_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [OUT_IDX_W-1:0]     saddle_row,
    output logic [OUT_IDX_W-1:0]     saddle_col,
    output logic signed [DATA_W-1:0] saddle_value
);

    logic              cfg_wr;
    logic              reg_sel;
    logic [SIZE_W-1:0] num_rows_reg;
    logic [SIZE_W-1:0] num_cols_reg;
    msp_cmd_t          cmd;
    msp_status_t       status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= SIZE_RESET;
            num_cols_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_NUM_ROWS: num_rows_reg <= pwdata[SIZE_W-1:0];
                REG_NUM_COLS: num_cols_reg <= pwdata[SIZE_W-1:0];
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_ROWS: prdata = APB_DATA_W'(num_rows_reg);
            REG_NUM_COLS: prdata = APB_DATA_W'(num_cols_reg);
            default:      prdata = '0;
        endcase
    end

    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    msp_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .restart      (cfg_wr),
        .num_rows     (num_rows_reg),
        .num_cols     (num_cols_reg),
        .elem_value   (elem_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .saddle_row   (saddle_row),
        .saddle_col   (saddle_col),
        .saddle_value (saddle_value)
    );

endmodule
